### sv/acss_pkg.sv
// acss_pkg: shared types, codes and reset values for the adc channel scan sequencer
// no dependencies; used by the interfaces, the top level and the checker
`default_nettype none

package acss_pkg;

  // field widths
  localparam int KIND_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int OKIND_W  = 2;
  localparam int CMD_W    = 11;
  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 16;
  localparam int CFG_IDX_W = 3;

  // number of per-channel setup words held, and default sweep length
  localparam int NUM_SETUP        = 5;
  localparam int NUM_CHANNELS_DEF = 5;

  // input event codes
  localparam logic [KIND_W-1:0] EV_START   = 3'd0;
  localparam logic [KIND_W-1:0] EV_TX_FREE = 3'd1;
  localparam logic [KIND_W-1:0] EV_RX_BYTE = 3'd2;
  localparam logic [KIND_W-1:0] EV_WAIT_OK = 3'd3;
  localparam logic [KIND_W-1:0] EV_ABORT   = 3'd4;

  // result codes
  localparam logic [OKIND_W-1:0] RES_CMD    = 2'd0;
  localparam logic [OKIND_W-1:0] RES_WAIT   = 2'd1;
  localparam logic [OKIND_W-1:0] RES_SAMPLE = 2'd2;

  // bus command word flag bits
  localparam int CMD_RESTART_BIT = 10;
  localparam int CMD_STOP_BIT    = 9;
  localparam int CMD_READ_BIT    = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_CH0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_CH4  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_PTR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_PTR = 3'd6;

  // register reset values
  localparam logic [WORD_W-1:0] SETUP_CH0_RST = 16'd34691;
  localparam logic [WORD_W-1:0] SETUP_CH1_RST = 16'd46979;
  localparam logic [WORD_W-1:0] SETUP_CH2_RST = 16'd42883;
  localparam logic [WORD_W-1:0] SETUP_CH3_RST = 16'd50051;
  localparam logic [WORD_W-1:0] SETUP_CH4_RST = 16'd58243;
  localparam logic [BYTE_W-1:0] SETUP_PTR_RST  = 8'd1;
  localparam logic [BYTE_W-1:0] RESULT_PTR_RST = 8'd0;

  // one result beat
  typedef struct packed {
    logic [OKIND_W-1:0]         out_kind;
    logic [CMD_W-1:0]           command_word;
    logic [CHAN_W-1:0]          sample_channel;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       sweep_done;
    logic                       last;
  } result_t;

endpackage

`default_nettype wire

### sv/acss_event_if.sv
// acss_event_if: valid/ready channel carrying one input event beat
// depends on acss_pkg
`default_nettype none

interface acss_event_if import acss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

`default_nettype wire

### sv/acss_result_if.sv
// acss_result_if: valid/ready channel carrying one result beat
// depends on acss_pkg
`default_nettype none

interface acss_result_if import acss_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OKIND_W-1:0]         out_kind;
  logic [CMD_W-1:0]           command_word;
  logic [CHAN_W-1:0]          sample_channel;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       sweep_done;
  logic                       last;

  modport source (output valid, output out_kind, output command_word, output sample_channel,
                  output sample_value, output sweep_done, output last, input ready);
  modport sink   (input valid, input out_kind, input command_word, input sample_channel,
                  input sample_value, input sweep_done, input last, output ready);
endinterface

`default_nettype wire

### sv/adc_channel_scan_sequencer.sv
// adc_channel_scan_sequencer: i2c converter channel sweep sequencer, top level
// an accepted event's first result beat shows in the next cycle if the queue is empty
// throughput: one event per cycle while the 4-entry result queue has room for two beats;
//   results leave one beat per cycle unless stalled; a two-result event yields two beats
// reset: synchronous; clears control state and result queue, restores register defaults
// depends on acss_pkg, acss_event_if, acss_result_if
`default_nettype none

module adc_channel_scan_sequencer import acss_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  acss_event_if.sink                events,
  acss_result_if.source             results,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [WORD_W-1:0]    wr_data
);

  // sequencer phases
  localparam logic [2:0] PH_IDLE        = 3'd0;
  localparam logic [2:0] PH_WRITE_SETUP = 3'd1;
  localparam logic [2:0] PH_WAIT        = 3'd2;
  localparam logic [2:0] PH_WRITE_PTR   = 3'd3;
  localparam logic [2:0] PH_READ_DATA   = 3'd4;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // configuration registers
  logic [WORD_W-1:0] setup_word [NUM_SETUP];
  logic [BYTE_W-1:0] setup_pointer;
  logic [BYTE_W-1:0] result_pointer;

  // sequencer state
  logic [2:0]        phase, phase_next;
  logic              busy, busy_next;
  logic [CHAN_W-1:0] chan_idx, chan_idx_next;
  logic [BYTE_W-1:0] byte_buf [3];
  logic [BYTE_W-1:0] byte_buf_next [3];
  logic [1:0]        byte_pos, byte_pos_next;
  logic [1:0]        byte_cnt, byte_cnt_next;

  // result queue
  result_t           rq [QDEPTH];
  logic [QPTR_W-1:0] rq_head;
  logic [QPTR_W:0]   rq_count;
  logic [QPTR_W-1:0] rq_tail;

  // event step outputs
  logic              accept;
  logic [1:0]        n_res;
  result_t           res0, res1;
  logic              pop;

  // helpers
  logic [CHAN_W-1:0] chan_inc;
  logic [WORD_W-1:0] word_first, word_nx;
  logic [1:0]        pos_inc, pos_rx;
  logic              done;
  logic              stop;

  assign accept  = events.valid && events.ready;
  assign events.ready = (rq_count <= (QPTR_W+1)'(QDEPTH - 2));
  assign pop     = results.valid && results.ready;
  assign rq_tail = rq_head + rq_count[QPTR_W-1:0];

  assign chan_inc   = chan_idx + 1'b1;
  assign word_first = setup_word[0];
  assign word_nx    = (chan_inc < CHAN_W'(NUM_SETUP)) ? setup_word[chan_inc] : '0;
  assign pos_inc    = byte_pos + 1'b1;
  assign done       = (4'(chan_idx) + 4'd1) >= 4'(NUM_CHANNELS);
  assign stop       = (pos_inc == byte_cnt) && (phase != PH_WRITE_PTR);

  // per-event sequencing
  always_comb begin
    phase_next    = phase;
    busy_next     = busy;
    chan_idx_next = chan_idx;
    byte_buf_next = byte_buf;
    byte_pos_next = byte_pos;
    byte_cnt_next = byte_cnt;
    pos_rx        = byte_pos;
    n_res         = 2'd0;
    res0          = '0;
    res1          = '0;
    if (accept) begin
      unique case (events.kind)
        EV_START: begin
          if (!busy) begin
            busy_next        = 1'b1;
            chan_idx_next    = '0;
            byte_buf_next[0] = setup_pointer;
            byte_buf_next[1] = word_first[15:8];
            byte_buf_next[2] = word_first[7:0];
            byte_pos_next    = 2'd0;
            byte_cnt_next    = 2'd3;
            phase_next       = PH_WRITE_SETUP;
          end
        end
        EV_TX_FREE: begin
          if (phase == PH_WRITE_SETUP || phase == PH_WRITE_PTR) begin
            if (byte_pos < byte_cnt && byte_pos < 2'd3) begin
              // send the next buffered byte
              res0.out_kind                   = RES_CMD;
              res0.command_word[BYTE_W-1:0]   = byte_buf[byte_pos];
              res0.command_word[CMD_STOP_BIT] = stop;
              res0.last                       = 1'b1;
              byte_pos_next                   = pos_inc;
              n_res                           = 2'd1;
            end else if (phase == PH_WRITE_SETUP) begin
              phase_next    = PH_WAIT;
              res0.out_kind = RES_WAIT;
              res0.last     = 1'b1;
              n_res         = 2'd1;
            end else begin
              // restart read, then stop read
              phase_next    = PH_READ_DATA;
              byte_pos_next = 2'd0;
              byte_cnt_next = 2'd2;
              res0.out_kind = RES_CMD;
              res0.command_word[CMD_RESTART_BIT] = 1'b1;
              res0.command_word[CMD_READ_BIT]    = 1'b1;
              res1.out_kind = RES_CMD;
              res1.command_word[CMD_STOP_BIT]    = 1'b1;
              res1.command_word[CMD_READ_BIT]    = 1'b1;
              res1.last     = 1'b1;
              n_res         = 2'd2;
            end
          end
        end
        EV_RX_BYTE: begin
          if (phase == PH_READ_DATA) begin
            if (byte_pos < byte_cnt && byte_pos < 2'd2) begin
              byte_buf_next[byte_pos] = events.rx_byte;
              pos_rx                  = pos_inc;
            end
            byte_pos_next = pos_rx;
            if (pos_rx >= byte_cnt) begin
              res0.out_kind       = RES_SAMPLE;
              res0.sample_channel = chan_idx;
              res0.sample_value   = {byte_buf_next[0], byte_buf_next[1]};
              res0.sweep_done     = done;
              res0.last           = 1'b1;
              n_res               = 2'd1;
              chan_idx_next       = chan_inc;
              if (!done) begin
                byte_buf_next[0] = setup_pointer;
                byte_buf_next[1] = word_nx[15:8];
                byte_buf_next[2] = word_nx[7:0];
                byte_pos_next    = 2'd0;
                byte_cnt_next    = 2'd3;
                phase_next       = PH_WRITE_SETUP;
              end else begin
                busy_next  = 1'b0;
                phase_next = PH_IDLE;
              end
            end
          end
        end
        EV_WAIT_OK: begin
          if (phase == PH_WAIT) begin
            byte_buf_next[0] = result_pointer;
            byte_pos_next    = 2'd0;
            byte_cnt_next    = 2'd1;
            phase_next       = PH_WRITE_PTR;
          end
        end
        EV_ABORT: begin
          busy_next  = 1'b0;
          phase_next = PH_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      busy           <= 1'b0;
      chan_idx       <= '0;
      byte_pos       <= '0;
      byte_cnt       <= '0;
      setup_word[0]  <= SETUP_CH0_RST;
      setup_word[1]  <= SETUP_CH1_RST;
      setup_word[2]  <= SETUP_CH2_RST;
      setup_word[3]  <= SETUP_CH3_RST;
      setup_word[4]  <= SETUP_CH4_RST;
      setup_pointer  <= SETUP_PTR_RST;
      result_pointer <= RESULT_PTR_RST;
    end else begin
      phase    <= phase_next;
      busy     <= busy_next;
      chan_idx <= chan_idx_next;
      byte_pos <= byte_pos_next;
      byte_cnt <= byte_cnt_next;
      if (wr_en) begin
        if (wr_index <= REG_SETUP_CH4) begin
          setup_word[wr_index - REG_SETUP_CH0] <= wr_data;
        end else if (wr_index == REG_SETUP_PTR) begin
          setup_pointer <= wr_data[BYTE_W-1:0];
        end else if (wr_index == REG_RESULT_PTR) begin
          result_pointer <= wr_data[BYTE_W-1:0];
        end
      end
    end
  end

  // byte buffer, no reset
  always_ff @(posedge clk) begin
    byte_buf <= byte_buf_next;
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_head  <= '0;
      rq_count <= '0;
    end else begin
      rq_head  <= rq_head + QPTR_W'(pop);
      rq_count <= rq_count + (QPTR_W+1)'(n_res) - (QPTR_W+1)'(pop);
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      rq[rq_tail] <= res0;
    end
    if (n_res == 2'd2) begin
      rq[rq_tail + 1'b1] <= res1;
    end
  end

  // result beat out of the queue head
  assign results.valid          = (rq_count != '0);
  assign results.out_kind       = rq[rq_head].out_kind;
  assign results.command_word   = rq[rq_head].command_word;
  assign results.sample_channel = rq[rq_head].sample_channel;
  assign results.sample_value   = rq[rq_head].sample_value;
  assign results.sweep_done     = rq[rq_head].sweep_done;
  assign results.last           = rq[rq_head].last;

endmodule

`default_nettype wire

### sv/acss_checker.sv
// acss_checker: port-level checks on the adc channel scan sequencer, bound to the top level
// depends on acss_pkg and adc_channel_scan_sequencer
`default_nettype none

module acss_checker import acss_pkg::*; (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [OKIND_W-1:0]         out_kind,
  input wire logic [CMD_W-1:0]           command_word,
  input wire logic signed [SAMPLE_W-1:0] sample_value,
  input wire logic                       last
);

  // a stalled result beat stays valid and holds its kind, command word, sample value and last flag
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(command_word)
      && $stable(sample_value) && $stable(last))
    else $error("stalled result beat changed");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // a sample or a wait request is always the only result of its event
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == RES_SAMPLE || out_kind == RES_WAIT) |-> last)
    else $error("sample or wait request not marked last");

  // only bus commands carry a command word
  a_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != RES_CMD |-> command_word == '0 && out_kind != 2'd3)
    else $error("command word on a non-command result");

endmodule

bind adc_channel_scan_sequencer acss_checker u_acss_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_kind     (results.out_kind),
  .command_word (results.command_word),
  .sample_value (results.sample_value),
  .last         (results.last)
);

`default_nettype wire
